[rtl/iiar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiar_pkg
// Shared types and codes for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iiar_pkg;

  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_INSERT     = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_GET        = 3'd3,
    REQ_SET        = 3'd4,
    REQ_SET_LENGTH = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SET
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [6:0]  position;
    logic [31:0] word_in;
    logic [6:0]  new_length;
  } in_word_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic [6:0]  current_length;
    logic [1:0]  status;
  } out_word_t;

endpackage

[rtl/iiar_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiar_cell
// One array slot. Compares its own index with the request position and the
// fill count, and loads the request word or a neighbour's entry.
// ----------------------------------------------------------------------------
module iiar_cell
  import iiar_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int CW        = 7,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  cell_op_t             op,
  input  logic [CW-1:0]        pos,
  input  logic [CW-1:0]        fill,
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] lower,
  input  logic [WORD_BITS-1:0] upper,
  output logic [WORD_BITS-1:0] data
);

  localparam logic [CW-1:0] MY_IDX  = CW'(INDEX);
  localparam logic [CW-1:0] MY_NEXT = CW'(INDEX + 1);

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (op)
      CELL_INSERT: begin
        if (MY_IDX == pos) begin
          data_nxt = word;
        end else if (MY_IDX > pos && MY_IDX <= fill) begin
          data_nxt = lower;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos && MY_NEXT < fill) begin
          data_nxt = upper;
        end
      end
      CELL_SET: begin
        if (MY_IDX == pos) begin
          data_nxt = word;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[rtl/iiar_gather.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iiar_gather
// Registered OR tree that collects the one selected slot word. One register
// level per tree level, from the leaf level up to the root.
// ----------------------------------------------------------------------------
module iiar_gather #(
  parameter int LEAVES    = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic [LEAVES-1:0][WORD_BITS-1:0]  leaf,
  output logic [WORD_BITS-1:0]              root
);

  localparam int LOG = $clog2(LEAVES);
  localparam int P   = 1 << LOG;

  logic [P-1:0][WORD_BITS-1:0] leaf_ext;
  logic [WORD_BITS-1:0]        node_r [P-1];

  always_comb begin
    leaf_ext = '0;
    leaf_ext[LEAVES-1:0] = leaf;
  end

  for (genvar i = 0; i < P - 1; i++) begin : g_node
    logic [WORD_BITS-1:0] left_v;
    logic [WORD_BITS-1:0] right_v;
    if (2 * i + 1 >= P - 1) begin : g_leaf
      assign left_v  = leaf_ext[2 * i + 1 - (P - 1)];
      assign right_v = leaf_ext[2 * i + 2 - (P - 1)];
    end else begin : g_inner
      assign left_v  = node_r[2 * i + 1];
      assign right_v = node_r[2 * i + 2];
    end
    always_ff @(posedge clk) begin
      node_r[i] <= left_v | right_v;
    end
  end

  assign root = node_r[0];

endmodule

[rtl/indexed_insert_remove_array.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Ordered word array with a length. Append, insert, remove, get, set and
// set-length requests over a row of slot cells that shift together on the same clock edge.
//
//   channel | ports                        | direction
//   --------+------------------------------+----------
//   request | in_valid  in_stall  in_word  | in
//   result  | out_valid out_stall out_word | out
//
// Every request waits in the busy state until the registered OR tree that
// reads the selected slot has settled, then its result is registered; the
// next request is taken once the result word has left, so one request is in
// flight at a time. Reset empties the array (length zero) at once;
// slot contents are not cleared. A stalled result holds in its register.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array
  import iiar_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int LEN_W = $clog2(CAPACITY + 1);
  localparam int CW    = (LEN_W > 7) ? LEN_W : 7;
  localparam int LOG   = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(LOG + 1);
  localparam logic [CW-1:0]    CAP_C = CW'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOG);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  in_word_t             req_r;
  out_word_t            out_r;
  logic                 accept;
  logic                 finish;

  logic [CW-1:0]        pos_x;
  logic [CW-1:0]        len_x;
  logic [CW-1:0]        cell_pos;
  logic [WORD_BITS-1:0] word_x;
  logic [63:0]          word_wide;
  logic [63:0]          root_wide;
  cell_op_t             dec_op;
  cell_op_t             cell_op;
  status_t              dec_status;
  logic                 dec_read;

  logic [CAPACITY-1:0][WORD_BITS-1:0] cell_q;
  logic [CAPACITY-1:0][WORD_BITS-1:0] leaf;
  logic [WORD_BITS-1:0]               root;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_word  = out_r;
  assign finish    = (state_r == ST_BUSY) && (cnt_r == CNT_LAST);

  assign pos_x     = CW'(req_r.position);
  assign len_x     = CW'(req_r.new_length);
  assign word_wide = {32'd0, req_r.word_in};
  assign word_x    = word_wide[WORD_BITS-1:0];
  assign root_wide = 64'(root);

  always_comb begin
    dec_op     = CELL_HOLD;
    dec_status = STAT_OK;
    dec_read   = 1'b0;
    fill_nxt   = fill_r;
    cell_pos   = pos_x;
    case (req_r.req_type)
      REQ_APPEND: begin
        cell_pos = fill_r;
        if (fill_r == CAP_C) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op   = CELL_INSERT;
          fill_nxt = fill_r + 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_x > fill_r) begin
          dec_status = STAT_BAD_INDEX;
        end else if (fill_r == CAP_C) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op   = CELL_INSERT;
          fill_nxt = fill_r + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_x >= fill_r) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          dec_op   = CELL_REMOVE;
          dec_read = 1'b1;
          fill_nxt = fill_r - 1'b1;
        end
      end
      REQ_GET: begin
        if (pos_x >= fill_r) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          dec_read = 1'b1;
        end
      end
      REQ_SET: begin
        if (pos_x >= fill_r) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          dec_op = CELL_SET;
        end
      end
      REQ_SET_LENGTH: begin
        if (len_x > CAP_C) begin
          dec_status = STAT_FULL;
        end else begin
          fill_nxt = len_x;
        end
      end
      default: dec_op = CELL_HOLD;
    endcase
  end

  assign cell_op = finish ? dec_op : CELL_HOLD;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_BITS-1:0] lower_v;
    logic [WORD_BITS-1:0] upper_v;
    if (k == 0) begin : g_first
      assign lower_v = '0;
    end else begin : g_lower
      assign lower_v = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign upper_v = '0;
    end else begin : g_upper
      assign upper_v = cell_q[k+1];
    end

    iiar_cell #(
      .WORD_BITS (WORD_BITS),
      .CW        (CW),
      .INDEX     (k)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .pos   (cell_pos),
      .fill  (fill_r),
      .word  (word_x),
      .lower (lower_v),
      .upper (upper_v),
      .data  (cell_q[k])
    );

    assign leaf[k] = (pos_x == CW'(k)) ? cell_q[k] : '0;
  end

  iiar_gather #(
    .LEAVES    (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_gather (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
          cnt_nxt   = '0;
        end
      end
      ST_BUSY: begin
        if (finish) begin
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (finish) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_word;
    end
    if (finish) begin
      out_r.word_out       <= dec_read ? root_wide[31:0] : 32'd0;
      out_r.current_length <= fill_nxt[6:0];
      out_r.status         <= dec_status;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_BUSY)
    else $error("accepted request did not start");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_C)
    else $error("length beyond capacity");

  a_fill_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !finish |=> fill_r == $past(fill_r))
    else $error("length changed outside request completion");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    finish && dec_op == CELL_REMOVE |=> fill_r == $past(fill_r) - 1'b1)
    else $error("remove did not shorten the array");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BUSY |-> cnt_r <= CNT_LAST)
    else $error("gather counter overran");

endmodule

[dv/tb_indexed_insert_remove_array.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_insert_remove_array
// Checks the indexed insert/remove array against a shadow copy of the array
// and its length kept in the bench. A short table of hand-picked requests
// runs first: the empty array, bad indexes, full, unused codes and length
// extremes. About eleven hundred random requests follow, in grow and shrink
// spells, so the array often runs full and empty. The sender pauses in bursts
// and the receiver stalls on its own pattern, with one long hold that backs
// the block up. Every reply word is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_indexed_insert_remove_array;
  import iiar_pkg::*;

  localparam int          CAP          = 64;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [2:0]  REQ_SPARE_LO = 3'd6;
  localparam logic [2:0]  REQ_SPARE_HI = 3'd7;

  typedef struct {
    in_word_t  req;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // shadow of the array: contents, whether each slot has ever been written
  logic [31:0] shadow_slot  [CAP];
  bit          shadow_known [CAP];
  logic [6:0]  shadow_len;
  int          peak_len;

  out_word_t   replies_due [$];
  int          mismatches;
  int          words_sent;
  int          replies_seen;
  int          n_bad_index;
  int          n_full;
  int          cycle_count;

  // length sequence: empty, build, unused codes, length limits, full, remove from the bottom
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{REQ_GET,        7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd0,  STAT_BAD_INDEX}},
    '{'{REQ_REMOVE,     7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd0,  STAT_BAD_INDEX}},
    '{'{REQ_SET,        7'd0,   32'hDEADBEEF, 7'd0},   1'b1, '{32'h0, 7'd0,  STAT_BAD_INDEX}},
    '{'{REQ_INSERT,     7'd1,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd0,  STAT_BAD_INDEX}},
    '{'{REQ_APPEND,     7'd0,   32'hFFFFFFFF, 7'd0},   1'b1, '{32'h0, 7'd1,  STAT_OK}},
    '{'{REQ_INSERT,     7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd2,  STAT_OK}},
    '{'{REQ_INSERT,     7'd2,   32'hA5A55A5A, 7'd0},   1'b1, '{32'h0, 7'd3,  STAT_OK}},
    '{'{REQ_GET,        7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd3,  STAT_OK}},
    '{'{REQ_GET,        7'd1,   32'h0,        7'd0},   1'b1,
      '{32'hFFFFFFFF, 7'd3, STAT_OK}},
    '{'{REQ_SET,        7'd1,   32'h12345678, 7'd0},   1'b1, '{32'h0, 7'd3,  STAT_OK}},
    '{'{REQ_REMOVE,     7'd1,   32'h0,        7'd0},   1'b1,
      '{32'h12345678, 7'd2, STAT_OK}},
    '{'{REQ_SPARE_LO,   7'd127, 32'hFFFFFFFF, 7'd127}, 1'b1, '{32'h0, 7'd2,  STAT_OK}},
    '{'{REQ_SPARE_HI,   7'd127, 32'hFFFFFFFF, 7'd127}, 1'b1, '{32'h0, 7'd2,  STAT_OK}},
    '{'{REQ_SET_LENGTH, 7'd0,   32'h0,        7'd65},  1'b1, '{32'h0, 7'd2,  STAT_FULL}},
    '{'{REQ_SET_LENGTH, 7'd0,   32'h0,        7'd127}, 1'b1, '{32'h0, 7'd2,  STAT_FULL}},
    '{'{REQ_SET_LENGTH, 7'd0,   32'h0,        7'd64},  1'b1, '{32'h0, 7'd64, STAT_OK}},
    '{'{REQ_APPEND,     7'd0,   32'h55AA55AA, 7'd0},   1'b1, '{32'h0, 7'd64, STAT_FULL}},
    '{'{REQ_INSERT,     7'd64,  32'h55AA55AA, 7'd0},   1'b1, '{32'h0, 7'd64, STAT_FULL}},
    '{'{REQ_INSERT,     7'd65,  32'h55AA55AA, 7'd0},   1'b1,
      '{32'h0, 7'd64, STAT_BAD_INDEX}},
    '{'{REQ_GET,        7'd127, 32'h0,        7'd0},   1'b1,
      '{32'h0, 7'd64, STAT_BAD_INDEX}},
    '{'{REQ_REMOVE,     7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd63, STAT_OK}},
    '{'{REQ_SET_LENGTH, 7'd0,   32'h0,        7'd0},   1'b1, '{32'h0, 7'd0,  STAT_OK}},
    '{'{REQ_SET_LENGTH, 7'd0,   32'h0,        7'd2},   1'b1, '{32'h0, 7'd2,  STAT_OK}},
    '{'{REQ_GET,        7'd0,   32'h0,        7'd0},   1'b0, '{32'h0, 7'd0,  STAT_OK}},
    '{'{REQ_REMOVE,     7'd0,   32'h0,        7'd0},   1'b0, '{32'h0, 7'd0,  STAT_OK}}
  };

  indexed_insert_remove_array u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // applies one request to the shadow array and returns the reply it gives
  function automatic out_word_t run_array_request(input in_word_t w);
    out_word_t  r;
    logic [6:0] at;
    int         k;
    r  = '0;
    r.status = STAT_OK;
    at = (w.req_type == REQ_APPEND) ? shadow_len : w.position;
    case (w.req_type)
      REQ_APPEND, REQ_INSERT: begin
        if (at > shadow_len) begin
          r.status = STAT_BAD_INDEX;
        end else if (shadow_len == CAP) begin
          r.status = STAT_FULL;
        end else begin
          for (k = shadow_len; k > at; k--) begin
            shadow_slot[k]  = shadow_slot[k-1];
            shadow_known[k] = shadow_known[k-1];
          end
          shadow_slot[at]  = w.word_in;
          shadow_known[at] = 1'b1;
          shadow_len++;
        end
      end
      REQ_REMOVE: begin
        if (w.position >= shadow_len) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          r.word_out = shadow_slot[w.position];
          for (k = w.position; k + 1 < shadow_len; k++) begin
            shadow_slot[k]  = shadow_slot[k+1];
            shadow_known[k] = shadow_known[k+1];
          end
          shadow_len--;
        end
      end
      REQ_GET: begin
        if (w.position >= shadow_len) r.status = STAT_BAD_INDEX;
        else r.word_out = shadow_slot[w.position];
      end
      REQ_SET: begin
        if (w.position >= shadow_len) begin
          r.status = STAT_BAD_INDEX;
        end else begin
          shadow_slot[w.position]  = w.word_in;
          shadow_known[w.position] = 1'b1;
        end
      end
      REQ_SET_LENGTH: begin
        if (w.new_length > CAP) r.status = STAT_FULL;
        else shadow_len = w.new_length;
      end
      default: ;
    endcase
    r.current_length = shadow_len;
    if (shadow_len > peak_len) peak_len = shadow_len;
    return r;
  endfunction

  // random request shaped by the current shadow length; never reads a slot
  // that has not been written since reset
  function automatic in_word_t pick_request(input bit grow);
    in_word_t    w;
    int unsigned roll;
    logic [2:0]  op;
    w.word_in    = $urandom;
    w.new_length = $urandom_range(127, 0);
    w.position   = $urandom_range(127, 0);
    roll = $urandom_range(99, 0);
    if      (roll < 25) op = REQ_APPEND;
    else if (roll < 50) op = REQ_INSERT;
    else if (roll < 62) op = REQ_REMOVE;
    else if (roll < 74) op = REQ_GET;
    else if (roll < 84) op = REQ_SET;
    else if (roll < 92) op = REQ_SET_LENGTH;
    else if (roll < 95) op = $urandom_range(REQ_SPARE_HI, REQ_SPARE_LO);
    else op = $urandom_range(7, 0);
    if (!grow && (op == REQ_APPEND || op == REQ_INSERT) && $urandom_range(3, 0) != 0)
      op = REQ_REMOVE;
    if (roll < 95) begin
      case (op)
        REQ_INSERT: begin
          if ($urandom_range(9, 0) != 0) w.position = $urandom_range(shadow_len, 0);
        end
        REQ_REMOVE, REQ_GET, REQ_SET: begin
          if (shadow_len != 0 && $urandom_range(9, 0) != 0)
            w.position = $urandom_range(shadow_len - 1, 0);
        end
        REQ_SET_LENGTH: begin
          if ($urandom_range(7, 0) != 0) w.new_length = $urandom_range(CAP, 0);
        end
        default: ;
      endcase
    end
    if ((op == REQ_GET || op == REQ_REMOVE) && w.position < shadow_len &&
        !shadow_known[w.position])
      op = REQ_SET;
    w.req_type = op;
    return w;
  endfunction

  task automatic send_request(input in_word_t w, input bit typed, input out_word_t res);
    out_word_t r;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = run_array_request(w);
    replies_due.push_back(typed ? res : r);
    words_sent++;
  endtask

  initial begin
    int          i;
    int unsigned burst_left;
    int unsigned gap;
    bit          growing;
    shadow_len  = '0;
    peak_len    = 0;
    mismatches  = 0;
    words_sent  = 0;
    burst_left  = 0;
    growing     = 1'b1;
    for (i = 0; i < CAP; i++) begin
      shadow_slot[i]  = '0;
      shadow_known[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (shadow_len == 0) growing = 1'b1;
      else if (shadow_len == CAP && $urandom_range(7, 0) == 0) growing = 1'b0;
      else if ($urandom_range(47, 0) == 0) growing = !growing;
      send_request(pick_request(growing), 1'b0, '0);
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(20, 1);
        gap = ($urandom_range(9, 0) < 4) ? 0 : $urandom_range(12, 1);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d request words and %0d replies, peak length %0d.",
             words_sent, replies_seen, peak_len);
    $display("Rejected: %0d bad index, %0d full; %0d mismatches.",
             n_bad_index, n_full, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: one long hold to back the block up, then mixed stall spells
  initial begin
    int unsigned span;
    int unsigned roll;
    repeat (600) @(posedge clk);
    out_stall <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    forever begin
      span = $urandom_range(60, 5);
      roll = $urandom_range(3, 0);
      repeat (span) begin
        case (roll)
          0:       out_stall <= 1'b0;
          1:       out_stall <= $urandom_range(1, 0);
          2:       out_stall <= ($urandom_range(3, 0) == 0);
          default: out_stall <= ($urandom_range(3, 0) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none due: word %h length %0d status %0d",
                 $time, out_word.word_out, out_word.current_length, out_word.status);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        if (want.status == STAT_BAD_INDEX) n_bad_index++;
        if (want.status == STAT_FULL) n_full++;
        if (out_word.word_out !== want.word_out) begin
          $display("%0t: word_out expected %h got %h", $time,
                   want.word_out, out_word.word_out);
          mismatches++;
        end
        if (out_word.current_length !== want.current_length) begin
          $display("%0t: current_length expected %0d got %0d", $time,
                   want.current_length, out_word.current_length);
          mismatches++;
        end
        if (out_word.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   want.status, out_word.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d replies still due", $time, replies_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count  = 0;
    replies_seen = 0;
    n_bad_index  = 0;
    n_full       = 0;
  end

endmodule
